// ===== hw/rtl/vrt_pkg.sv =====
package vrt_pkg;

   localparam int ORIGIN_W = 24;
   localparam int DIR_W    = 16;
   localparam int DIST_W   = 23;
   localparam int VOX_W    = 12;
   localparam int NRM_W    = 2;
   localparam int FIX_W    = 32;
   localparam int AXES     = 3;

   localparam logic [FIX_W-1:0] FIX_INF = '1;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_REPLY = 1'b1
   } item_kind_type;

   typedef enum logic [1:0] {
      RES_QUERY = 2'd0,
      RES_HIT   = 2'd1,
      RES_MISS  = 2'd2
   } result_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUMSQ,
      ST_SQRT,
      ST_AXIS,
      ST_DIV,
      ST_MUL,
      ST_EMIT
   } back_state_type;

   // One classified request as it waits between front and back.
   typedef struct packed {
      item_kind_type                  kind;
      logic                           miss_now;
      logic                           solid;
      logic [AXES-1:0][ORIGIN_W-1:0]  origin;
      logic [AXES-1:0][DIR_W-1:0]     dir;
      logic [DIST_W-1:0]              max_distance;
   } cmd_type;

endpackage

// ===== hw/rtl/vrt_if.sv =====
interface vrt_req_if import vrt_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic signed [ORIGIN_W-1:0] origin_x;
   logic signed [ORIGIN_W-1:0] origin_y;
   logic signed [ORIGIN_W-1:0] origin_z;
   logic signed [DIR_W-1:0]    dir_x;
   logic signed [DIR_W-1:0]    dir_y;
   logic signed [DIR_W-1:0]    dir_z;
   logic [DIST_W-1:0]          max_distance;
   logic                       solid;

   modport source (output valid, kind, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   max_distance, solid, input ready);
   modport sink   (input valid, kind, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   max_distance, solid, output ready);
endinterface

interface vrt_rsp_if import vrt_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              result_kind;
   logic signed [VOX_W-1:0] voxel_x;
   logic signed [VOX_W-1:0] voxel_y;
   logic signed [VOX_W-1:0] voxel_z;
   logic signed [NRM_W-1:0] normal_x;
   logic signed [NRM_W-1:0] normal_y;
   logic signed [NRM_W-1:0] normal_z;

   modport source (output valid, result_kind, voxel_x, voxel_y, voxel_z,
                   normal_x, normal_y, normal_z, input ready);
   modport sink   (input valid, result_kind, voxel_x, voxel_y, voxel_z,
                   normal_x, normal_y, normal_z, output ready);
endinterface

// ===== hw/rtl/vrt_front.sv =====
module vrt_front import vrt_pkg::*; #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 12
) (
   vrt_req_if.sink   req_chan,
   input  logic      queue_full,
   output logic      push,
   output cmd_type   cmd
);

   localparam int VW = ORIGIN_W + 1;
   localparam logic signed [VW-1:0] VOX_LO = -(VW'(1) <<< (COORD_BITS - 1));
   localparam logic signed [VW-1:0] VOX_HI = (VW'(1) <<< (COORD_BITS - 1)) - VW'(1);

   logic signed [VW-1:0] vox [AXES];
   logic                 out_of_range;
   logic                 dir_zero;

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   // Take the integer voxel of each origin axis and check it against the range.
   always_comb begin
      vox[0]       = VW'(req_chan.origin_x >>> FRAC_BITS);
      vox[1]       = VW'(req_chan.origin_y >>> FRAC_BITS);
      vox[2]       = VW'(req_chan.origin_z >>> FRAC_BITS);
      out_of_range = 1'b0;
      for (int a = 0; a < AXES; a++) begin
         if (vox[a] < VOX_LO || vox[a] > VOX_HI) begin
            out_of_range = 1'b1;
         end
      end
      dir_zero = (req_chan.dir_x == '0) && (req_chan.dir_y == '0) && (req_chan.dir_z == '0);
   end

   always_comb begin
      cmd.kind         = item_kind_type'(req_chan.kind);
      cmd.solid        = req_chan.solid;
      cmd.origin       = {req_chan.origin_z, req_chan.origin_y, req_chan.origin_x};
      cmd.dir          = {req_chan.dir_z, req_chan.dir_y, req_chan.dir_x};
      cmd.max_distance = req_chan.max_distance;
      cmd.miss_now     = dir_zero || (req_chan.max_distance == '0) || out_of_range;
   end

endmodule

// ===== hw/rtl/vrt_queue.sv =====
module vrt_queue import vrt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/vrt_back.sv =====
module vrt_back import vrt_pkg::*; #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 12
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     cmd_valid,
   input  cmd_type  cmd,
   output logic     cmd_pop,
   vrt_rsp_if.source rsp_chan
);

   localparam int CW = COORD_BITS;
   localparam int PW = FRAC_BITS + 1;
   localparam logic [PW-1:0] ONE_FIX = PW'(1) << FRAC_BITS;

   back_state_type state_ff, state_in;

   cmd_type               cmd_ff, cmd_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic [1:0]            axis_ff, axis_in;
   logic [FIX_W-1:0]      acc_ff, acc_in;
   logic [2*FIX_W-1:0]    rad_ff, rad_in;
   logic [FIX_W:0]        rem_ff, rem_in;
   logic [FIX_W-1:0]      root_ff, root_in;
   logic [FIX_W-1:0]      quo_ff, quo_in;
   logic [DIR_W-1:0]      drem_ff, drem_in;
   logic [DIR_W-1:0]      mag_ff, mag_in;

   logic signed [CW-1:0]    voxel_ff [AXES];
   logic signed [CW-1:0]    voxel_in [AXES];
   logic signed [1:0]       sign_ff  [AXES];
   logic signed [1:0]       sign_in  [AXES];
   logic [FIX_W-1:0]        next_ff  [AXES];
   logic [FIX_W-1:0]        next_in  [AXES];
   logic [FIX_W-1:0]        delta_ff [AXES];
   logic [FIX_W-1:0]        delta_in [AXES];
   logic signed [NRM_W-1:0] normal_ff [AXES];
   logic signed [NRM_W-1:0] normal_in [AXES];
   logic [FIX_W-1:0]        limit_ff, limit_in;
   logic                    active_ff, active_in;

   logic                    out_valid_ff, out_valid_in;
   result_kind_type         out_kind_ff;
   logic signed [CW-1:0]    out_vox_ff [AXES];
   logic signed [NRM_W-1:0] out_nrm_ff [AXES];

   // Combinational helpers
   logic                    out_free;
   logic                    take;
   logic                    emit;
   result_kind_type         emit_kind;
   logic signed [CW-1:0]    emit_vox [AXES];
   logic signed [NRM_W-1:0] emit_nrm [AXES];

   logic [1:0]              ax;
   logic [FIX_W:0]          cross_sum;
   logic [FIX_W-1:0]        cross_sat;
   logic signed [CW:0]      step_vox;
   logic                    step_out;
   logic                    step_miss;

   logic signed [DIR_W-1:0] sq_dir;
   logic signed [FIX_W-1:0] sq_prod;
   logic [FIX_W-1:0]        acc_sum;
   logic [FIX_W+2:0]        rem_sh;
   logic [FIX_W+2:0]        trial;
   logic [DIR_W:0]          div_sh;
   logic signed [DIR_W-1:0] ax_dir;
   logic [FRAC_BITS-1:0]    ax_frac;
   logic [PW-1:0]           part;
   logic [PW+FIX_W-1:0]     prod;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign take     = (state_ff == ST_IDLE) && cmd_valid && out_free;
   assign cmd_pop  = take;

   // Pick the axis with the nearest boundary, ties to x then y.
   always_comb begin
      if (next_ff[0] <= next_ff[1] && next_ff[0] <= next_ff[2]) begin
         ax = 2'd0;
      end else if (next_ff[1] <= next_ff[2]) begin
         ax = 2'd1;
      end else begin
         ax = 2'd2;
      end
      cross_sum = {1'b0, next_ff[ax]} + {1'b0, delta_ff[ax]};
      cross_sat = (cross_sum >= {1'b0, FIX_INF}) ? FIX_INF : cross_sum[FIX_W-1:0];
      step_vox  = (CW+1)'(voxel_ff[ax]) + (CW+1)'(sign_ff[ax]);
      step_out  = step_vox[CW] != step_vox[CW-1];
      step_miss = (next_ff[ax] > limit_ff) || step_out;
   end

   always_comb begin
      sq_dir  = $signed(cmd_ff.dir[cnt_ff[1:0]]);
      sq_prod = sq_dir * sq_dir;
      acc_sum = acc_ff + $unsigned(sq_prod);
      rem_sh  = {rem_ff, rad_ff[2*FIX_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      div_sh  = {drem_ff, quo_ff[FIX_W-1]};
      ax_dir  = $signed(cmd_ff.dir[axis_ff]);
      ax_frac = cmd_ff.origin[axis_ff][FRAC_BITS-1:0];
      part    = (sign_ff[axis_ff] == 2'sd1) ? (ONE_FIX - PW'(ax_frac)) : PW'(ax_frac);
      prod    = part * delta_ff[axis_ff];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take && cmd.kind == KIND_START && !cmd.miss_now) begin
               state_in = ST_SUMSQ;
            end
         end
         ST_SUMSQ: begin
            if (cnt_ff == 5'd2) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (cnt_ff == 5'd31) state_in = ST_AXIS;
         end
         ST_AXIS: begin
            if (ax_dir != '0) begin
               state_in = ST_DIV;
            end else if (axis_ff == 2'd2) begin
               state_in = ST_EMIT;
            end
         end
         ST_DIV: begin
            if (cnt_ff == 5'd31) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = (axis_ff == 2'd2) ? ST_EMIT : ST_AXIS;
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result selection
   always_comb begin
      emit      = 1'b0;
      emit_kind = RES_MISS;
      for (int a = 0; a < AXES; a++) begin
         emit_vox[a] = '0;
         emit_nrm[a] = '0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (cmd.kind == KIND_START) begin
                  if (cmd.miss_now) begin
                     emit      = 1'b1;
                     emit_kind = RES_MISS;
                  end
               end else if (active_ff) begin
                  emit = 1'b1;
                  if (cmd.solid) begin
                     emit_kind = RES_HIT;
                     for (int a = 0; a < AXES; a++) begin
                        emit_vox[a] = voxel_ff[a];
                        emit_nrm[a] = normal_ff[a];
                     end
                  end else if (step_miss) begin
                     emit_kind = RES_MISS;
                  end else begin
                     emit_kind = RES_QUERY;
                     for (int a = 0; a < AXES; a++) begin
                        emit_vox[a] = (a == int'(ax)) ? step_vox[CW-1:0] : voxel_ff[a];
                     end
                  end
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_kind = RES_QUERY;
               for (int a = 0; a < AXES; a++) begin
                  emit_vox[a] = voxel_ff[a];
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      cmd_in    = cmd_ff;
      cnt_in    = cnt_ff;
      axis_in   = axis_ff;
      acc_in    = acc_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      quo_in    = quo_ff;
      drem_in   = drem_ff;
      mag_in    = mag_ff;
      limit_in  = limit_ff;
      active_in = active_ff;
      for (int a = 0; a < AXES; a++) begin
         voxel_in[a]  = voxel_ff[a];
         sign_in[a]   = sign_ff[a];
         next_in[a]   = next_ff[a];
         delta_in[a]  = delta_ff[a];
         normal_in[a] = normal_ff[a];
      end
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd_in = cmd;
               if (cmd.kind == KIND_START) begin
                  active_in = 1'b0;
                  limit_in  = FIX_W'({{(FIX_W-DIST_W){1'b0}}, cmd.max_distance}
                                     << (16 - FRAC_BITS));
                  acc_in    = '0;
                  cnt_in    = '0;
                  axis_in   = '0;
               end else if (active_ff) begin
                  if (cmd.solid) begin
                     active_in = 1'b0;
                  end else begin
                     next_in[ax] = cross_sat;
                     for (int a = 0; a < AXES; a++) normal_in[a] = '0;
                     normal_in[ax] = -sign_ff[ax];
                     if (step_miss) begin
                        active_in = 1'b0;
                     end else begin
                        voxel_in[ax] = step_vox[CW-1:0];
                     end
                  end
               end
            end
         end
         ST_SUMSQ: begin
            acc_in = acc_sum;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd2) begin
               rad_in  = {acc_sum, {FIX_W{1'b0}}};
               rem_in  = '0;
               root_in = '0;
               cnt_in  = '0;
            end
         end
         ST_SQRT: begin
            // One root bit a cycle, two radicand bits in.
            rad_in = rad_ff << 2;
            cnt_in = cnt_ff + 5'd1;
            if (rem_sh >= trial) begin
               rem_in  = (FIX_W+1)'(rem_sh - trial);
               root_in = {root_ff[FIX_W-2:0], 1'b1};
            end else begin
               rem_in  = (FIX_W+1)'(rem_sh);
               root_in = {root_ff[FIX_W-2:0], 1'b0};
            end
            if (cnt_ff == 5'd31) axis_in = '0;
         end
         ST_AXIS: begin
            voxel_in[axis_ff]  = CW'($signed(cmd_ff.origin[axis_ff]) >>> FRAC_BITS);
            normal_in[axis_ff] = '0;
            if (ax_dir == '0) begin
               sign_in[axis_ff]  = 2'sd0;
               delta_in[axis_ff] = FIX_INF;
               next_in[axis_ff]  = FIX_INF;
               axis_in           = axis_ff + 2'd1;
            end else begin
               sign_in[axis_ff] = ax_dir[DIR_W-1] ? -2'sd1 : 2'sd1;
               mag_in           = ax_dir[DIR_W-1] ? DIR_W'(-ax_dir) : DIR_W'(ax_dir);
               quo_in           = root_ff;
               drem_in          = '0;
               cnt_in           = '0;
            end
         end
         ST_DIV: begin
            // Restoring division, one quotient bit a cycle.
            cnt_in = cnt_ff + 5'd1;
            if (div_sh >= {1'b0, mag_ff}) begin
               drem_in = DIR_W'(div_sh - {1'b0, mag_ff});
               quo_in  = {quo_ff[FIX_W-2:0], 1'b1};
            end else begin
               drem_in = div_sh[DIR_W-1:0];
               quo_in  = {quo_ff[FIX_W-2:0], 1'b0};
            end
            if (cnt_ff == 5'd31) delta_in[axis_ff] = quo_in;
         end
         ST_MUL: begin
            next_in[axis_ff] = FIX_W'(prod >> FRAC_BITS);
            axis_in          = axis_ff + 2'd1;
         end
         ST_EMIT: begin
            if (out_free) active_in = 1'b1;
         end
         default: begin
            active_in = active_ff;
         end
      endcase
   end

   assign out_valid_in = emit ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         limit_ff     <= '0;
         for (int a = 0; a < AXES; a++) begin
            voxel_ff[a]  <= '0;
            sign_ff[a]   <= '0;
            next_ff[a]   <= FIX_INF;
            delta_ff[a]  <= FIX_INF;
            normal_ff[a] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
         limit_ff     <= limit_in;
         for (int a = 0; a < AXES; a++) begin
            voxel_ff[a]  <= voxel_in[a];
            sign_ff[a]   <= sign_in[a];
            next_ff[a]   <= next_in[a];
            delta_ff[a]  <= delta_in[a];
            normal_ff[a] <= normal_in[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      cnt_ff  <= cnt_in;
      axis_ff <= axis_in;
      acc_ff  <= acc_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      quo_ff  <= quo_in;
      drem_ff <= drem_in;
      mag_ff  <= mag_in;
      if (emit) begin
         out_kind_ff <= emit_kind;
         for (int a = 0; a < AXES; a++) begin
            out_vox_ff[a] <= emit_vox[a];
            out_nrm_ff[a] <= emit_nrm[a];
         end
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.result_kind = out_kind_ff;
   assign rsp_chan.voxel_x     = VOX_W'(out_vox_ff[0]);
   assign rsp_chan.voxel_y     = VOX_W'(out_vox_ff[1]);
   assign rsp_chan.voxel_z     = VOX_W'(out_vox_ff[2]);
   assign rsp_chan.normal_x    = out_nrm_ff[0];
   assign rsp_chan.normal_y    = out_nrm_ff[1];
   assign rsp_chan.normal_z    = out_nrm_ff[2];

endmodule

// ===== hw/rtl/voxel_ray_traversal.sv =====
// Channel   Dir  Role          Content
// req_chan  in   sink          start (origin, direction, reach) or reply (solid)
// rsp_chan  out  source        query voxel, hit with entry normal, or miss
//
// A reply passes through the queue, then the back end registers its result,
// set by the three-way compare and the crossing add.
// A start forms the squared length, then the root (one bit a cycle), then,
// per moving axis, a division in the shared divider and the first-crossing
// multiply.
// Reset is synchronous and clears control state, the queue and the ray.
// A two-entry queue parts front and back; a held result stalls the back end,
// and intake stops once both queue entries are taken.
module voxel_ray_traversal import vrt_pkg::*; #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 12
) (
   input  logic       clock,
   input  logic       reset,
   vrt_req_if.sink    req_chan,
   vrt_rsp_if.source  rsp_chan
);

   logic    push;
   logic    pop;
   logic    full;
   logic    not_empty;
   cmd_type push_cmd;
   cmd_type head;

   // Front end: classify each request and flag the rays that miss at once.
   vrt_front #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .req_chan   (req_chan),
      .queue_full (full),
      .push       (push),
      .cmd        (push_cmd)
   );

   // Hold classified requests until the back end is free.
   vrt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head)
   );

   // Back end: ray set-up (root, divisions, multiplies) and voxel stepping.
   vrt_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (not_empty),
      .cmd       (head),
      .cmd_pop   (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== hw/rtl/vrt_checker.sv =====
module vrt_checker import vrt_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [1:0]              rsp_result_kind,
   input logic signed [VOX_W-1:0] rsp_voxel_x,
   input logic signed [VOX_W-1:0] rsp_voxel_y,
   input logic signed [VOX_W-1:0] rsp_voxel_z,
   input logic signed [NRM_W-1:0] rsp_normal_x,
   input logic signed [NRM_W-1:0] rsp_normal_y,
   input logic signed [NRM_W-1:0] rsp_normal_z
);

   logic nrm_zero;
   assign nrm_zero = (rsp_normal_x == '0) && (rsp_normal_y == '0) && (rsp_normal_z == '0);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind))
      else $error("result dropped while stalled");

   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == RES_MISS |->
         rsp_voxel_x == '0 && rsp_voxel_y == '0 && rsp_voxel_z == '0 && nrm_zero)
      else $error("miss carries voxel or normal");

   a_query_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == RES_QUERY |-> nrm_zero)
      else $error("query carries a normal");

   a_hit_one_face: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == RES_HIT |->
         $countones({rsp_normal_x != '0, rsp_normal_y != '0, rsp_normal_z != '0}) <= 1)
      else $error("hit normal on more than one axis");

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_result_kind (rsp_chan.result_kind),
   .rsp_voxel_x     (rsp_chan.voxel_x),
   .rsp_voxel_y     (rsp_chan.voxel_y),
   .rsp_voxel_z     (rsp_chan.voxel_z),
   .rsp_normal_x    (rsp_chan.normal_x),
   .rsp_normal_y    (rsp_chan.normal_y),
   .rsp_normal_z    (rsp_chan.normal_z)
);

// ===== test/tb_voxel_ray_traversal.sv =====
module tb_voxel_ray_traversal;
   import vrt_pkg::*;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 12;
   localparam int WATCHDOG   = 20000;

   // One request as the driver sends it.
   typedef struct {
      item_kind_type           kind;
      logic [ORIGIN_W-1:0]     org [AXES];
      logic [DIR_W-1:0]        dir [AXES];
      logic [DIST_W-1:0]       max_distance;
      logic                    solid;
   } ray_req_type;

   // One response as the block should give it.
   typedef struct {
      logic [1:0]        kind;
      logic [VOX_W-1:0]  vox [AXES];
      logic [NRM_W-1:0]  nrm [AXES];
   } ray_rsp_type;

   logic clock;
   logic reset;

   vrt_req_if req_chan ();
   vrt_rsp_if rsp_chan ();

   voxel_ray_traversal #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // Traversal state of the predictor; crossings, limit, steps and normals at the block's widths, voxels at 32 bits.
   logic signed [31:0] trk_voxel [AXES];
   logic signed [1:0]  trk_step  [AXES];
   logic [31:0]        trk_next  [AXES];
   logic [31:0]        trk_delta [AXES];
   logic signed [1:0]  trk_normal [AXES];
   logic [31:0]        trk_limit;
   logic               trk_active;

   ray_req_type pending_reqs [$];
   ray_rsp_type expected_rsps [$];

   int  error_count;
   int  rsp_seen;
   int  hits_seen;
   int  misses_seen;
   int  idle_cycles;
   bit  stimulus_done;
   bit  hold_sender;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic logic [63:0] root64(input logic [63:0] n);
      logic [63:0] r, b, rem;
      r = 0; rem = n; b = 64'd1 << 62;
      while (b > rem) b >>= 2;
      while (b != 0) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic bit coord_ok(input longint v);
      longint half;
      half = longint'(1) << (COORD_BITS - 1);
      return v >= -half && v <= half - 1;
   endfunction

   function automatic ray_rsp_type make_rsp(input logic [1:0] k, input bit with_vox,
                                            input bit with_nrm);
      ray_rsp_type r;
      r.kind = k;
      for (int i = 0; i < AXES; i++) begin
         r.vox[i] = with_vox ? trk_voxel[i][VOX_W-1:0] : '0;
         r.nrm[i] = with_nrm ? trk_normal[i] : '0;
      end
      return r;
   endfunction

   // Advance the predictor by one request; returns 1 and the response if one is due.
   function automatic bit trace_ray(input ray_req_type q, output ray_rsp_type r);
      longint      o, d, nv;
      logic [63:0] s, len, frac, mag, dl, part, sum;
      int          ax;
      logic [31:0] travelled;
      r = make_rsp(RES_MISS, 0, 0);
      if (q.kind == KIND_START) begin
         trk_active = 0;
         s = 0;
         for (int i = 0; i < AXES; i++) begin
            d = longint'($signed(q.dir[i]));
            s += d * d;
         end
         if (s == 0 || q.max_distance == 0) return 1;
         len = root64(s << 32);
         for (int i = 0; i < AXES; i++) begin
            o = longint'($signed(q.org[i]));
            d = longint'($signed(q.dir[i]));
            frac = o & ((64'd1 << FRAC_BITS) - 1);
            nv = (o - longint'(frac)) >>> FRAC_BITS;
            if (!coord_ok(nv)) return 1;
            trk_voxel[i] = 32'(nv);
            trk_normal[i] = '0;
            if (d == 0) begin
               trk_step[i] = '0;
               trk_delta[i] = FIX_INF;
               trk_next[i] = FIX_INF;
            end else begin
               mag = d < 0 ? -d : d;
               dl = len / mag;
               if (dl > 64'hFFFF_FFFF) dl = 64'hFFFF_FFFF;
               trk_delta[i] = dl[31:0];
               trk_step[i] = d > 0 ? 2'sd1 : -2'sd1;
               part = d > 0 ? ((64'd1 << FRAC_BITS) - frac) : frac;
               trk_next[i] = 32'((part * dl) >> FRAC_BITS);
            end
         end
         trk_limit = 32'(64'(q.max_distance) << (16 - FRAC_BITS));
         trk_active = 1;
         r = make_rsp(RES_QUERY, 1, 0);
         return 1;
      end
      if (!trk_active) return 0;
      if (q.solid) begin
         trk_active = 0;
         r = make_rsp(RES_HIT, 1, 1);
         return 1;
      end
      // Smallest crossing wins; ties to x, then y.
      if (trk_next[0] <= trk_next[1] && trk_next[0] <= trk_next[2]) ax = 0;
      else if (trk_next[1] <= trk_next[2]) ax = 1;
      else ax = 2;
      travelled = trk_next[ax];
      sum = 64'(trk_next[ax]) + 64'(trk_delta[ax]);
      trk_next[ax] = sum >= 64'hFFFF_FFFF ? FIX_INF : sum[31:0];
      nv = longint'(trk_voxel[ax]) + longint'(trk_step[ax]);
      for (int i = 0; i < AXES; i++) trk_normal[i] = '0;
      trk_normal[ax] = -trk_step[ax];
      if (travelled > trk_limit || !coord_ok(nv)) begin
         trk_active = 0;
         r = make_rsp(RES_MISS, 0, 0);
         return 1;
      end
      trk_voxel[ax] = 32'(nv);
      r = make_rsp(RES_QUERY, 1, 0);
      return 1;
   endfunction

   function automatic ray_req_type start_req(input int ox, input int oy, input int oz,
                                             input int dx, input int dy, input int dz,
                                             input int maxd);
      ray_req_type q;
      q.kind = KIND_START;
      q.org[0] = ORIGIN_W'(ox); q.org[1] = ORIGIN_W'(oy); q.org[2] = ORIGIN_W'(oz);
      q.dir[0] = DIR_W'(dx); q.dir[1] = DIR_W'(dy); q.dir[2] = DIR_W'(dz);
      q.max_distance = DIST_W'(maxd);
      q.solid = 1'($urandom_range(0, 1));
      return q;
   endfunction

   function automatic ray_req_type reply_req(input bit solid);
      ray_req_type q;
      q.kind = KIND_REPLY;
      for (int i = 0; i < AXES; i++) begin
         q.org[i] = ORIGIN_W'($urandom);
         q.dir[i] = DIR_W'($urandom);
      end
      q.max_distance = DIST_W'($urandom);
      q.solid = solid;
      return q;
   endfunction

   function automatic int rand_dir();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return $urandom_range(0, 1) ? 32767 : -32768;
         2:       return int'($urandom_range(0, 8)) - 4;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   function automatic int rand_origin();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 1) ? 8388607 : -8388608;
         1:       return (int'($urandom_range(0, 1)) ? 2047 : -2048) * 4096
                         + int'($urandom_range(0, 4095));
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // Directed part: extremes, zero direction, zero reach, stepping out of the range,
   // hits in the origin voxel and after steps.
   task automatic fill_directed();
      pending_reqs.push_back(reply_req(1));
      pending_reqs.push_back(reply_req(0));
      pending_reqs.push_back(start_req(0, 0, 0, 0, 0, 0, 100));
      pending_reqs.push_back(start_req(0, 0, 0, 1, 0, 0, 0));
      pending_reqs.push_back(start_req(8388607, 0, 0, 1, 1, 1, 8388607));
      pending_reqs.push_back(start_req(0, 0, 0, 1, 2, 3, 8388607));
      pending_reqs.push_back(reply_req(1));
      pending_reqs.push_back(start_req(2047 * 4096 + 4095, -8388608, 0, 32767, -32768, 0,
                                       8388607));
      pending_reqs.push_back(reply_req(0));
      pending_reqs.push_back(reply_req(0));
      pending_reqs.push_back(start_req(-2048 * 4096, 2048, -1, -32768, 32767, -1, 8388607));
      pending_reqs.push_back(reply_req(0));
      pending_reqs.push_back(reply_req(0));
      pending_reqs.push_back(reply_req(1));
      pending_reqs.push_back(start_req(2048, 2048, 2048, 1, 1, 1, 4096));
      for (int i = 0; i < 4; i++) pending_reqs.push_back(reply_req(0));
      pending_reqs.push_back(start_req(100, 200, 300, 5, -7, 0, 20000));
      pending_reqs.push_back(start_req(0, 0, 0, 0, 0, -32768, 8388607));
      pending_reqs.push_back(reply_req(0));
      pending_reqs.push_back(reply_req(1));
   endtask

   task automatic fill_random();
      int steps;
      int total;
      total = 0;
      while (total < 400) begin
         if ($urandom_range(0, 9) == 0) begin
            pending_reqs.push_back(reply_req($urandom_range(0, 1)));
         end else begin
            pending_reqs.push_back(start_req(rand_origin(), rand_origin(), rand_origin(),
                                             rand_dir(), rand_dir(), rand_dir(),
                                             $urandom_range(0, 7) == 0 ? 0 :
                                             $urandom_range(0, 3) == 0 ? 8388607 :
                                             $urandom_range(1, 40000)));
            // Keep most rays short so starts and replies stay balanced.
            steps = $urandom_range(0, 12);
            for (int j = 0; j < steps; j++) pending_reqs.push_back(reply_req(0));
            if ($urandom_range(0, 3) != 0) pending_reqs.push_back(reply_req(1));
            total += steps + 2;
         end
      end
   endtask

   // Sender: bursts of random length with random gaps, plus one full pause.
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            ray_rsp_type r;
            ray_req_type q;
            q.kind = item_kind_type'(req_chan.kind);
            q.org[0] = req_chan.origin_x; q.org[1] = req_chan.origin_y;
            q.org[2] = req_chan.origin_z;
            q.dir[0] = req_chan.dir_x; q.dir[1] = req_chan.dir_y; q.dir[2] = req_chan.dir_z;
            q.max_distance = req_chan.max_distance;
            q.solid = req_chan.solid;
            if (trace_ray(q, r)) expected_rsps.push_back(r);
         end
         if (req_chan.valid && !req_chan.ready) begin
            // hold the request until it is taken
         end else if (gap_left > 0) begin
            req_chan.valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (hold_sender || pending_reqs.size() == 0) begin
            req_chan.valid <= 1'b0;
         end else begin
            ray_req_type n;
            n = pending_reqs.pop_front();
            req_chan.valid        <= 1'b1;
            req_chan.kind         <= n.kind;
            req_chan.origin_x     <= n.org[0];
            req_chan.origin_y     <= n.org[1];
            req_chan.origin_z     <= n.org[2];
            req_chan.dir_x        <= n.dir[0];
            req_chan.dir_y        <= n.dir[1];
            req_chan.dir_z        <= n.dir[2];
            req_chan.max_distance <= n.max_distance;
            req_chan.solid        <= n.solid;
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(0, 20);
               gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
            end
         end
      end
   end

   // Receiver: stall on a slowly changing pattern of its own.
   int stall_phase;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         case ((stall_phase >> 8) % 4)
            0:       rsp_chan.ready <= 1'b1;
            1:       rsp_chan.ready <= $urandom_range(0, 3) != 0;
            2:       rsp_chan.ready <= $urandom_range(0, 3) == 0;
            default: rsp_chan.ready <= (stall_phase % 7) < 3;
         endcase
      end
   end

   // Monitor: compare each accepted response with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_seen++;
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response kind", rsp_chan.result_kind, 0);
         end else begin
            ray_rsp_type e;
            e = expected_rsps.pop_front();
            if (e.kind == RES_HIT) hits_seen++;
            if (e.kind == RES_MISS) misses_seen++;
            if (rsp_chan.result_kind !== e.kind)
               report_mismatch("result_kind", rsp_chan.result_kind, e.kind);
            if (rsp_chan.voxel_x !== e.vox[0]) report_mismatch("voxel_x", rsp_chan.voxel_x, e.vox[0]);
            if (rsp_chan.voxel_y !== e.vox[1]) report_mismatch("voxel_y", rsp_chan.voxel_y, e.vox[1]);
            if (rsp_chan.voxel_z !== e.vox[2]) report_mismatch("voxel_z", rsp_chan.voxel_z, e.vox[2]);
            if (rsp_chan.normal_x !== e.nrm[0])
               report_mismatch("normal_x", rsp_chan.normal_x, e.nrm[0]);
            if (rsp_chan.normal_y !== e.nrm[1])
               report_mismatch("normal_y", rsp_chan.normal_y, e.nrm[1]);
            if (rsp_chan.normal_z !== e.nrm[2])
               report_mismatch("normal_z", rsp_chan.normal_z, e.nrm[2]);
         end
      end
   end

   // Watchdog: count cycles in which no request or response moves, until the stimulus has drained.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (stimulus_done && expected_rsps.size() == 0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog expired with %0d responses outstanding", expected_rsps.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      rsp_seen = 0;
      hits_seen = 0;
      misses_seen = 0;
      idle_cycles = 0;
      stimulus_done = 0;
      hold_sender = 1;
      trk_active = 0;
      trk_limit = 0;
      for (int i = 0; i < AXES; i++) begin
         trk_voxel[i] = 0; trk_step[i] = '0; trk_normal[i] = '0;
         trk_next[i] = FIX_INF; trk_delta[i] = FIX_INF;
      end
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.kind = 1'b0;
      req_chan.origin_x = '0; req_chan.origin_y = '0; req_chan.origin_z = '0;
      req_chan.dir_x = '0; req_chan.dir_y = '0; req_chan.dir_z = '0;
      req_chan.max_distance = '0;
      req_chan.solid = 1'b0;
      rsp_chan.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      fill_directed();
      hold_sender <= 1'b0;
      wait (pending_reqs.size() == 0 && !req_chan.valid);
      // Pause the sender until the directed part has drained.
      hold_sender <= 1'b1;
      wait (expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      fill_random();
      @(posedge clock);
      hold_sender <= 1'b0;
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      wait (!req_chan.valid);
      stimulus_done = 1;
      wait (expected_rsps.size() == 0);
      repeat (300) @(posedge clock);
      $display("covered %0d responses: %0d hits, %0d misses, rest voxel queries",
               rsp_seen, hits_seen, misses_seen);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
